[design/msam_pkg.sv]
package msam_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STREAM_W = 3;
    localparam int MASK_W   = 8;
    localparam int ACTIVE_W = 4;
    localparam int LIMIT_W  = 11;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 11;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_MIX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 8'd1;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd512;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic trim;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic none_active;
        logic last_stream;
        logic out_free;
    } dp_stat_t;

endpackage

[design/multi_stream_audio_mixer.sv]
// An accepted push is written to its stream FIFO in S_PUSH and acknowledged from S_DONE.
// A tick runs a FIFO read step (S_POP) and an accumulate-and-trim step (S_TRIM) on each active
// stream before S_DONE. A new word is taken only in S_IDLE, once the last result is registered;
// a result that is still waiting on m_tready holds the next result back until it is taken.
// Reset (aresetn low, synchronous) empties every stream FIFO and restores the registers to
// eight active streams and a backlog limit of 512; the sample memory itself is not cleared.
module multi_stream_audio_mixer #(
    parameter int MAX_STREAMS = 8,
    parameter int FIFO_DEPTH  = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // stream [2:0], sample [18:3], zero [23:19]
    input  logic        s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mixed_sample [15:0], starved_mask [23:16], push_dropped [24]
    output logic        m_tuser,   // kind [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import msam_pkg::*;

    logic [ACTIVE_W-1:0] active_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [SAMPLE_W-1:0] out_mixed;
    logic [MASK_W-1:0]   out_starved;
    logic                out_dropped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RST;
            limit_reg  <= LIMIT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ACTIVE) begin
                active_reg <= cfg_data[ACTIVE_W-1:0];
            end else if (cfg_index == CFG_LIMIT) begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    msam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    msam_dp #(
        .MAX_STREAMS (MAX_STREAMS),
        .FIFO_DEPTH  (FIFO_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .active_streams (active_reg),
        .backlog_limit  (limit_reg),
        .in_cmd         (s_tuser),
        .in_stream      (s_tdata[2:0]),
        .in_sample      (s_tdata[18:3]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_mixed      (out_mixed),
        .out_starved    (out_starved),
        .out_dropped    (out_dropped)
    );

    assign m_tdata = {7'd0, out_dropped, out_starved, out_mixed};

endmodule

[design/msam_ctrl.sv]
module msam_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    output msam_pkg::dp_cmd_t cmd,
    input  msam_pkg::dp_stat_t stat
);
    import msam_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_TRIM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_cmd == CMD_PUSH) begin
                        state_next = S_PUSH;
                    end else if (stat.none_active) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_POP;
                    end
                end
            end
            S_PUSH: begin
                cmd.push   = 1'b1;
                state_next = S_DONE;
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = S_TRIM;
            end
            S_TRIM: begin
                cmd.trim   = 1'b1;
                state_next = stat.last_stream ? S_DONE : S_POP;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/msam_dp.sv]
module msam_dp #(
    parameter int MAX_STREAMS = 8,
    parameter int FIFO_DEPTH  = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  msam_pkg::dp_cmd_t                  cmd,
    output msam_pkg::dp_stat_t                 stat,
    input  logic [msam_pkg::ACTIVE_W-1:0]      active_streams,
    input  logic [msam_pkg::LIMIT_W-1:0]       backlog_limit,
    input  logic                               in_cmd,
    input  logic [msam_pkg::STREAM_W-1:0]      in_stream,
    input  logic [msam_pkg::SAMPLE_W-1:0]      in_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_kind,
    output logic [msam_pkg::SAMPLE_W-1:0]      out_mixed,
    output logic [msam_pkg::MASK_W-1:0]        out_starved,
    output logic                               out_dropped
);
    import msam_pkg::*;

    localparam int SW        = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int NW        = $clog2(MAX_STREAMS + 1) + 1;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int LW        = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int MEM_DEPTH = MAX_STREAMS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MW        = (MAX_STREAMS > MASK_W) ? MAX_STREAMS : MASK_W;
    localparam int ACC_W     = SAMPLE_W + $clog2(MAX_STREAMS) + 1;

    localparam logic [PTR_W:0]       DEPTH_X  = (PTR_W + 1)'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0]     DEPTH_C  = CNT_W'(FIFO_DEPTH);
    localparam logic [NW-1:0]        MAX_N    = NW'(MAX_STREAMS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32767);

    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] s);
        return (s >= DEPTH_X) ? PTR_W'(s - DEPTH_X) : PTR_W'(s);
    endfunction

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    logic [PTR_W-1:0] ri_reg [MAX_STREAMS];
    logic [CNT_W-1:0] fc_reg [MAX_STREAMS];

    logic                  cmd_reg;
    logic [STREAM_W-1:0]   stream_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SW-1:0]         idx_reg;
    logic                  hit_reg;
    logic                  drop_reg;
    logic [MW-1:0]         mask_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [SAMPLE_W-1:0]   out_mixed_reg;
    logic [MASK_W-1:0]     out_starved_reg;
    logic                  out_dropped_reg;

    logic [NW-1:0]         n_act;
    logic                  stream_ok;
    logic [SW-1:0]         cur_idx;
    logic [PTR_W-1:0]      cur_ri;
    logic [CNT_W-1:0]      cur_fc;
    logic [ADDR_W-1:0]     base_addr;
    logic [PTR_W-1:0]      push_pos;
    logic                  push_ok;
    logic                  pop_hit;
    logic [LW-1:0]         fc_ext;
    logic [LW-1:0]         lim_ext;
    logic                  over;
    logic [CNT_W-1:0]      drop_cnt;
    logic [PTR_W-1:0]      trim_ri;
    logic [SAMPLE_W-1:0]   sat_val;

    assign n_act     = ({1'b0, active_streams} > MAX_N) ? MAX_N
                                                         : NW'(active_streams);
    assign stream_ok = ({29'd0, stream_reg} < 32'(MAX_STREAMS));
    assign cur_idx   = (cmd_reg == CMD_TICK) ? idx_reg : SW'(stream_reg);
    assign cur_ri    = ri_reg[cur_idx];
    assign cur_fc    = fc_reg[cur_idx];
    assign base_addr = ADDR_W'(cur_idx) * ADDR_W'(FIFO_DEPTH);
    assign push_pos  = wrap_ptr((PTR_W + 1)'(cur_ri) + (PTR_W + 1)'(cur_fc));
    assign push_ok   = stream_ok && (cur_fc != DEPTH_C);
    assign pop_hit   = (cur_fc != '0);
    assign fc_ext    = LW'(cur_fc);
    assign lim_ext   = LW'(backlog_limit);
    assign over      = (fc_ext > lim_ext);
    assign drop_cnt  = CNT_W'(fc_ext - lim_ext);
    assign trim_ri   = wrap_ptr((PTR_W + 1)'(cur_ri) + (PTR_W + 1)'(drop_cnt));
    assign sat_val   = (acc_reg > SAT_HI) ? SAMPLE_W'(SAT_HI) :
                       (acc_reg < SAT_LO) ? SAMPLE_W'(SAT_LO) : SAMPLE_W'(acc_reg);

    assign stat.none_active = (n_act == '0);
    assign stat.last_stream = ((NW'(idx_reg) + NW'(1)) == n_act);
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.push && push_ok) begin
            mem[base_addr + ADDR_W'(push_pos)] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            rdata_reg <= mem[base_addr + ADDR_W'(cur_ri)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_STREAMS; i++) begin
                ri_reg[i] <= '0;
                fc_reg[i] <= '0;
            end
        end else if (cmd.push && push_ok) begin
            fc_reg[cur_idx] <= cur_fc + CNT_W'(1);
        end else if (cmd.pop && pop_hit) begin
            ri_reg[cur_idx] <= wrap_ptr((PTR_W + 1)'(cur_ri) + (PTR_W + 1)'(1));
            fc_reg[cur_idx] <= cur_fc - CNT_W'(1);
        end else if (cmd.trim && over) begin
            ri_reg[cur_idx] <= trim_ri;
            fc_reg[cur_idx] <= CNT_W'(backlog_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= in_cmd;
            stream_reg <= in_stream;
            sample_reg <= in_sample;
            idx_reg    <= '0;
            acc_reg    <= '0;
            mask_reg   <= '0;
            drop_reg   <= 1'b0;
        end
        if (cmd.push) begin
            drop_reg <= !push_ok;
        end
        if (cmd.pop) begin
            hit_reg <= pop_hit;
            if (!pop_hit) begin
                mask_reg[cur_idx] <= 1'b1;
            end
        end
        if (cmd.trim) begin
            idx_reg <= idx_reg + SW'(1);
            if (hit_reg) begin
                acc_reg <= acc_reg + {{(ACC_W - SAMPLE_W){rdata_reg[SAMPLE_W-1]}}, rdata_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (cmd_reg == CMD_TICK) begin
                out_kind_reg    <= KIND_MIX;
                out_mixed_reg   <= sat_val;
                out_starved_reg <= mask_reg[MASK_W-1:0];
                out_dropped_reg <= 1'b0;
            end else begin
                out_kind_reg    <= KIND_ACK;
                out_mixed_reg   <= '0;
                out_starved_reg <= '0;
                out_dropped_reg <= drop_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_mixed   = out_mixed_reg;
    assign out_starved = out_starved_reg;
    assign out_dropped = out_dropped_reg;

endmodule

[verif/tb_multi_stream_audio_mixer.sv]
module tb_multi_stream_audio_mixer;
    import msam_pkg::*;

    localparam int MAX_STREAMS = 8;
    localparam int FIFO_DEPTH  = 1024;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 64;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] mixed;
        logic [MASK_W-1:0]   starved;
        logic                dropped;
    } mix_word_t;

    class mixer_scoreboard;
        logic [SAMPLE_W-1:0] fifo_mem [MAX_STREAMS][FIFO_DEPTH];
        int unsigned head [MAX_STREAMS];
        int unsigned level [MAX_STREAMS];
        int unsigned active_cfg;
        int unsigned limit_cfg;
        mix_word_t owed_words [$];
        int errors;
        int ticks;
        int pushes;
        int drops;
        int checked;

        function new();
            for (int i = 0; i < MAX_STREAMS; i++) begin
                head[i] = 0;
                level[i] = 0;
            end
            active_cfg = ACTIVE_RST;
            limit_cfg = LIMIT_RST;
            errors = 0;
            ticks = 0;
            pushes = 0;
            drops = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_ACTIVE) begin
                active_cfg = data[ACTIVE_W-1:0];
            end else if (idx == CFG_LIMIT) begin
                limit_cfg = data[LIMIT_W-1:0];
            end
        endfunction

        function int unsigned mixed_count();
            return (active_cfg > MAX_STREAMS) ? MAX_STREAMS : active_cfg;
        endfunction

        // Predicts the result of one accepted word and updates the stream FIFOs.
        function void take_word(logic cmd, logic [STREAM_W-1:0] stream,
                                logic [SAMPLE_W-1:0] sample);
            mix_word_t w;
            int unsigned n;
            int sum;
            w = '0;
            if (cmd == CMD_PUSH) begin
                w.kind = KIND_ACK;
                pushes++;
                if (level[stream] < FIFO_DEPTH) begin
                    fifo_mem[stream][(head[stream] + level[stream]) % FIFO_DEPTH] = sample;
                    level[stream]++;
                end else begin
                    w.dropped = 1'b1;
                    drops++;
                end
            end else begin
                w.kind = KIND_MIX;
                ticks++;
                n = mixed_count();
                sum = 0;
                for (int i = 0; i < n; i++) begin
                    if (level[i] != 0) begin
                        sum += int'($signed(fifo_mem[i][head[i]]));
                        head[i] = (head[i] + 1) % FIFO_DEPTH;
                        level[i]--;
                    end else begin
                        w.starved[i] = 1'b1;
                    end
                end
                if (sum > 32767) sum = 32767;
                if (sum < -32767) sum = -32767;
                w.mixed = 16'(sum);
                for (int i = 0; i < n; i++) begin
                    if (level[i] > limit_cfg) begin
                        head[i] = (head[i] + level[i] - limit_cfg) % FIFO_DEPTH;
                        level[i] = limit_cfg;
                    end
                end
            end
            owed_words = {owed_words, w};
        endfunction

        function void check_word(logic kind, logic [31:0] data);
            mix_word_t w;
            if (owed_words.size() == 0) begin
                $error("Result word with none outstanding: kind %0d, data %h", kind, data);
                errors++;
                return;
            end
            w = owed_words[0];
            owed_words.delete(0);
            checked++;
            if (kind !== w.kind) begin
                $error("kind: expected %0d, got %0d", w.kind, kind);
                errors++;
            end
            if (data[15:0] !== w.mixed) begin
                $error("mixed_sample: expected %0d, got %0d",
                       $signed(w.mixed), $signed(data[15:0]));
                errors++;
            end
            if (data[23:16] !== w.starved) begin
                $error("starved_mask: expected %h, got %h", w.starved, data[23:16]);
                errors++;
            end
            if (data[24] !== w.dropped) begin
                $error("push_dropped: expected %0d, got %0d", w.dropped, data[24]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    mixer_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_cycles = 0;
    int settings_used = 0;

    multi_stream_audio_mixer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tuser, m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("tb_multi_stream_audio_mixer failed");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic [STREAM_W-1:0] stream,
                             input logic [SAMPLE_W-1:0] sample);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, sample, stream};
        do @(posedge aclk); while (!s_tready);
        sb.take_word(cmd, stream, sample);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, CFG_DAT_W'(value));
    endtask

    task automatic configure(input int unsigned active, input int unsigned limit);
        drain();
        write_reg(CFG_ACTIVE, active);
        write_reg(CFG_LIMIT, limit);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sd32767;
            1: return 16'h8000;
            2, 3: return SAMPLE_W'($urandom_range(200) - 100);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_random(input int count);
        int unsigned n;
        logic [STREAM_W-1:0] stream;
        for (int k = 0; k < count; k++) begin
            n = sb.mixed_count();
            if ($urandom_range(99) < 22) begin
                send_word(CMD_TICK, STREAM_W'($urandom), SAMPLE_W'($urandom));
            end else begin
                if (n != 0 && $urandom_range(99) < 80) begin
                    stream = STREAM_W'($urandom_range(n - 1));
                end else begin
                    stream = STREAM_W'($urandom);
                end
                send_word(CMD_PUSH, stream, pick_sample());
            end
        end
    endtask

    int unsigned phase_active [RANDOM_PHASES] = '{8, 1, 15, 3, 8, 5, 0, 7};
    int unsigned phase_limit [RANDOM_PHASES] = '{2, 1, 3, 0, 1024, 2047, 4, 6};
    int idle_modes [4][2] = '{'{0, 0}, '{77, 0}, '{0, 77}, '{25, 25}};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(8, 1024);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        for (int i = 0; i < 4; i++) send_word(CMD_PUSH, 3'(i), 16'sd32767);
        send_word(CMD_TICK, 3'd7, 16'hffff);
        send_word(CMD_PUSH, 3'd0, 16'h8000);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        for (int i = 0; i < MAX_STREAMS; i++) send_word(CMD_PUSH, 3'(i), 16'h8000);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        send_word(CMD_PUSH, 3'd7, 16'h0001);
        send_word(CMD_PUSH, 3'd6, 16'hffff);
        send_word(CMD_PUSH, 3'd5, 16'h0000);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        configure(0, 1024);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        configure(15, 1024);
        send_word(CMD_PUSH, 3'd7, 16'h7ffe);
        send_word(CMD_TICK, 3'd0, 16'h0000);

        // Overfill an inactive stream until pushes are refused, then mix it back in.
        configure(2, 2047);
        for (int i = 0; i < FIFO_DEPTH + 6; i++) begin
            send_word(CMD_PUSH, 3'd7, pick_sample());
        end
        configure(8, 2047);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        send_word(CMD_PUSH, 3'd7, 16'h1234);
        configure(8, 0);
        send_word(CMD_TICK, 3'd0, 16'h0000);
        send_word(CMD_TICK, 3'd0, 16'h0000);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure(phase_active[p], phase_limit[p]);
            send_idle_pct = idle_modes[p % 4][0];
            recv_stall_pct = idle_modes[p % 4][1];
            run_random(WORDS_PER_PHASE);
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d pushes (%0d refused by a full FIFO) and %0d mix ticks",
                 sb.pushes, sb.drops, sb.ticks);
        $display("over %0d register settings; %0d result words compared, %0d mismatches.",
                 settings_used, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_multi_stream_audio_mixer passed");
        end else begin
            $display("tb_multi_stream_audio_mixer failed");
        end
        $finish;
    end

endmodule
